### src/r2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_pkg
// Shared constants for the rectangular to polar converter: angle accumulator
// format, gain correction factor and the arctangent table.
// ----------------------------------------------------------------------------
package r2p_pkg;

  // extra fraction bits carried through the rotation stages
  localparam int GUARD_BITS = 8;

  // angle accumulator in units of pi / 2^31
  localparam int ANGLE_ACC_W = 34;
  localparam int ATAN_W      = 32;

  // output angle in units of pi / 2^15
  localparam int ANGLE_W     = 17;
  localparam int ANGLE_SHIFT = 16;
  localparam int ANGLE_MAX   = 32768;

  localparam logic signed [ANGLE_ACC_W-1:0] PI_ACC      = 34'sh0_8000_0000;
  localparam logic signed [ANGLE_ACC_W-1:0] HALF_PI_ACC = 34'sh0_4000_0000;

  // inverse cordic gain 0x9B74EDA8 / 2^32, split into two halves
  localparam logic [15:0] INV_GAIN_HI = 16'h9B74;
  localparam logic [15:0] INV_GAIN_LO = 16'hEDA8;

  // atan(2^-i) in units of pi / 2^31
  localparam logic [ATAN_W-1:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

### src/r2p_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_prep
// Input stage: folds the left half plane into the right one, sets the start
// angle and detects the axis cases that bypass the rotations.
// ----------------------------------------------------------------------------
module r2p_prep
  import r2p_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  output logic                                         ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]               real_part_i,
  input  logic signed [SAMPLE_WIDTH-1:0]               imag_part_i,
  output logic                                         valid_o,
  input  logic                                         ready_i,
  output logic                                         bypass_o,
  output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0]    x_o,
  output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0]    y_o,
  output logic signed [ANGLE_ACC_W-1:0]                z_o
);

  localparam int XW = SAMPLE_WIDTH + GUARD_BITS + 3;

  logic                        valid_q;
  logic                        bypass_d, bypass_q;
  logic signed [XW-1:0]        x_d, x_q, y_d, y_q;
  logic signed [ANGLE_ACC_W-1:0] z_d, z_q;
  logic signed [XW-1:0]        re_ext, im_ext, re_abs, im_abs;
  logic                        re_neg, im_neg, re_zero, im_zero;

  // sign extension and absolute values
  assign re_ext  = {{(XW-SAMPLE_WIDTH){real_part_i[SAMPLE_WIDTH-1]}}, real_part_i};
  assign im_ext  = {{(XW-SAMPLE_WIDTH){imag_part_i[SAMPLE_WIDTH-1]}}, imag_part_i};
  assign re_neg  = real_part_i[SAMPLE_WIDTH-1];
  assign im_neg  = imag_part_i[SAMPLE_WIDTH-1];
  assign re_zero = (real_part_i == '0);
  assign im_zero = (imag_part_i == '0);
  assign re_abs  = re_neg ? -re_ext : re_ext;
  assign im_abs  = im_neg ? -im_ext : im_ext;

  // start vector and start angle
  always_comb begin
    bypass_d = 1'b0;
    x_d      = '0;
    y_d      = '0;
    z_d      = '0;
    priority if (im_zero) begin
      // on the real axis: magnitude is |re|, angle 0 or +pi
      bypass_d = 1'b1;
      x_d      = re_abs;
      z_d      = re_neg ? PI_ACC : '0;
    end else if (re_zero) begin
      // on the imaginary axis: magnitude is |im|, angle +/- pi/2
      bypass_d = 1'b1;
      x_d      = im_abs;
      z_d      = im_neg ? -HALF_PI_ACC : HALF_PI_ACC;
    end else if (re_neg) begin
      // turn through pi into the right half plane
      x_d = (-re_ext) <<< GUARD_BITS;
      y_d = (-im_ext) <<< GUARD_BITS;
      z_d = im_neg ? -PI_ACC : PI_ACC;
    end else begin
      x_d = re_ext <<< GUARD_BITS;
      y_d = im_ext <<< GUARD_BITS;
    end
  end

  // stage handshake
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      bypass_q <= bypass_d;
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
    end
  end

  assign valid_o  = valid_q;
  assign bypass_o = bypass_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign z_o      = z_q;

endmodule

### src/r2p_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_rotate
// One vectoring micro-rotation: drives y toward zero by atan(2^-STEP) and
// accumulates the turned angle. Axis items pass through unchanged.
// ----------------------------------------------------------------------------
module r2p_rotate
  import r2p_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STEP         = 0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  logic                                      bypass_i,
  input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] x_i,
  input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] y_i,
  input  logic signed [ANGLE_ACC_W-1:0]             z_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output logic                                      bypass_o,
  output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] x_o,
  output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] y_o,
  output logic signed [ANGLE_ACC_W-1:0]             z_o
);

  localparam int XW = SAMPLE_WIDTH + GUARD_BITS + 3;
  localparam logic signed [ANGLE_ACC_W-1:0] ATAN_STEP =
    {{(ANGLE_ACC_W-ATAN_W){1'b0}}, ATAN_TABLE[STEP]};

  logic                          valid_q, bypass_q;
  logic signed [XW-1:0]          x_d, x_q, y_d, y_q, dx, dy;
  logic signed [ANGLE_ACC_W-1:0] z_d, z_q;

  // shifts truncate toward zero
  assign dx = y_i[XW-1] ? -((-y_i) >>> STEP) : (y_i >>> STEP);
  assign dy = x_i[XW-1] ? -((-x_i) >>> STEP) : (x_i >>> STEP);

  // micro-rotation in the direction that shrinks |y|
  always_comb begin
    priority if (bypass_i) begin
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (!y_i[XW-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN_STEP;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN_STEP;
    end
  end

  // stage handshake
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      bypass_q <= bypass_i;
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
    end
  end

  assign valid_o  = valid_q;
  assign bypass_o = bypass_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign z_o      = z_q;

endmodule

### src/r2p_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2p_scale
// Output stages: removes the cordic gain from x and rounds it to the input
// scale, and rounds and clamps the accumulated angle. Two register stages.
// ----------------------------------------------------------------------------
module r2p_scale
  import r2p_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  logic                                      bypass_i,
  input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] x_i,
  input  logic signed [ANGLE_ACC_W-1:0]             z_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output logic        [SAMPLE_WIDTH-1:0]            magnitude_o,
  output logic signed [ANGLE_W-1:0]                 angle_o
);

  localparam int XW    = SAMPLE_WIDTH + GUARD_BITS + 3;
  localparam int PW    = XW + 16;
  localparam int SUM_W = PW + 1;
  localparam int MAG_SHIFT = 16 + GUARD_BITS;
  localparam int MW    = SUM_W - MAG_SHIFT;
  localparam int RW    = ANGLE_ACC_W - ANGLE_SHIFT + 1;

  // first stage: gain products
  logic                          a_valid_q, a_bypass_q, a_ready;
  logic [XW-1:0]                 ux;
  logic [PW-1:0]                 hi_d, lo_d, hi_q, lo_q;
  logic [SAMPLE_WIDTH-1:0]       a_byp_mag_q;
  logic signed [ANGLE_ACC_W-1:0] a_z_q;

  // second stage: rounding and output register
  logic                          b_valid_q, b_ready;
  logic [SUM_W-1:0]              mag_sum;
  logic [MW-1:0]                 mag_full;
  logic [SAMPLE_WIDTH-1:0]       mag_d, mag_q;
  logic                          z_neg;
  logic [ANGLE_ACC_W-1:0]        z_abs;
  logic [RW-1:0]                 r_abs, r_clamp;
  logic signed [ANGLE_W-1:0]     angle_d, angle_q;

  // multiply by the inverse gain, negative x taken as zero
  assign ux   = x_i[XW-1] ? '0 : XW'(x_i);
  assign hi_d = PW'(ux) * PW'(INV_GAIN_HI);
  assign lo_d = PW'(ux) * PW'(INV_GAIN_LO);

  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && a_ready) begin
      hi_q        <= hi_d;
      lo_q        <= lo_d;
      a_bypass_q  <= bypass_i;
      a_byp_mag_q <= x_i[SAMPLE_WIDTH-1:0];
      a_z_q       <= z_i;
    end
  end

  // magnitude: round half up and saturate
  assign mag_sum  = SUM_W'(hi_q) + (SUM_W'(1) << (MAG_SHIFT - 1)) + SUM_W'(lo_q >> 16);
  assign mag_full = mag_sum[SUM_W-1:MAG_SHIFT];

  always_comb begin
    if (a_bypass_q) begin
      mag_d = a_byp_mag_q;
    end else if (|mag_full[MW-1:SAMPLE_WIDTH]) begin
      mag_d = '1;
    end else begin
      mag_d = mag_full[SAMPLE_WIDTH-1:0];
    end
  end

  // angle: round half away from zero and clamp to +/- pi
  assign z_neg = a_z_q[ANGLE_ACC_W-1];
  assign z_abs = z_neg ? ANGLE_ACC_W'(-a_z_q) : ANGLE_ACC_W'(a_z_q);
  assign r_abs = RW'((z_abs + (ANGLE_ACC_W'(1) << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT);
  assign r_clamp = (r_abs > RW'(ANGLE_MAX)) ? RW'(ANGLE_MAX) : r_abs;
  assign angle_d = z_neg ? -ANGLE_W'(r_clamp) : ANGLE_W'(r_clamp);

  assign b_ready = !b_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      mag_q   <= mag_d;
      angle_q <= angle_d;
    end
  end

  assign valid_o     = b_valid_q;
  assign magnitude_o = mag_q;
  assign angle_o     = angle_q;

endmodule

### src/rect_to_polar_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_to_polar_converter
// Rectangular to polar conversion of one complex sample per cycle while the
// output is not stalled, by a fully unrolled cordic vectoring pipeline.
// ----------------------------------------------------------------------------
// The converter takes one sample every clock cycle while the output is not
// stalled, and returns its rounded modulus at the input scale and its
// four-quadrant argument in units of pi/32768 (+32768 is +pi, a negative real
// axis value gives +pi, zero gives angle 0). The pipeline holds one folding
// stage, one register stage per micro-rotation and two stages for gain
// correction and rounding. Every stage holds its own valid bit, so a stalled
// output only blocks the input once the pipeline has no empty stage left.
module rect_to_polar_converter
  import r2p_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int ROTATION_STEPS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] real_part_i,
  input  logic signed [SAMPLE_WIDTH-1:0] imag_part_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic        [SAMPLE_WIDTH-1:0] magnitude_o,
  output logic signed [ANGLE_W-1:0]      angle_o
);

  localparam int XW = SAMPLE_WIDTH + GUARD_BITS + 3;

  // inter-stage links, index 0 is the folding stage output
  logic                          st_valid  [ROTATION_STEPS+1];
  logic                          st_ready  [ROTATION_STEPS+1];
  logic                          st_bypass [ROTATION_STEPS+1];
  logic signed [XW-1:0]          st_x      [ROTATION_STEPS+1];
  logic signed [XW-1:0]          st_y      [ROTATION_STEPS+1];
  logic signed [ANGLE_ACC_W-1:0] st_z      [ROTATION_STEPS+1];

  // quadrant folding and axis detection
  r2p_prep #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .real_part_i(real_part_i),
    .imag_part_i(imag_part_i),
    .valid_o    (st_valid[0]),
    .ready_i    (st_ready[0]),
    .bypass_o   (st_bypass[0]),
    .x_o        (st_x[0]),
    .y_o        (st_y[0]),
    .z_o        (st_z[0])
  );

  // micro-rotation stages
  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_rot
    r2p_rotate #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .STEP        (i)
    ) u_rotate (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[i]),
      .ready_o (st_ready[i]),
      .bypass_i(st_bypass[i]),
      .x_i     (st_x[i]),
      .y_i     (st_y[i]),
      .z_i     (st_z[i]),
      .valid_o (st_valid[i+1]),
      .ready_i (st_ready[i+1]),
      .bypass_o(st_bypass[i+1]),
      .x_o     (st_x[i+1]),
      .y_o     (st_y[i+1]),
      .z_o     (st_z[i+1])
    );
  end

  // gain correction and rounding
  r2p_scale #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (st_valid[ROTATION_STEPS]),
    .ready_o    (st_ready[ROTATION_STEPS]),
    .bypass_i   (st_bypass[ROTATION_STEPS]),
    .x_i        (st_x[ROTATION_STEPS]),
    .z_i        (st_z[ROTATION_STEPS]),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .magnitude_o(magnitude_o),
    .angle_o    (angle_o)
  );

  // the final y is not needed
  logic y_unused;
  assign y_unused = ^st_y[ROTATION_STEPS];

endmodule
